// File: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Radix register value after reset, and the one radix that shows a sign.
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] DECIMAL     = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;

  // ASCII codes used by the character emitter.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  // Classification of one job, passed from the front end to the back end.
  typedef struct packed {
    logic       neg;
    logic [5:0] radix;
  } job_ctl_t;

  // One output word: a character and its end-of-number flag.
  typedef struct packed {
    logic       last;
    logic [7:0] ch;
  } char_word_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_RD,
    BK_EMIT
  } back_state_e;

endpackage

// File: design/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts integers to ASCII digit strings in a configurable radix 2 to 36.
// ----------------------------------------------------------------------------
// Usage. An input word is taken when push is high and full is low; value_i
// holds the integer. Each input word yields one or more output words, one
// character each, most significant first, with last_char_o set on the final
// character. A result word sits on char_out_o/last_char_o while empty is low
// and is taken when pop is high. Digits above nine are lower-case letters.
// In radix ten a negative value starts with '-'; other radixes read the bits
// as unsigned. The user writes the radix register (cfg_we_i/cfg_radix_i)
// while the block is idle, not enforced; values below 2 or above 36 saturate.
// Flow. The front end classifies a value in the accept cycle and queues it
// (two entries). The back end takes a job, then runs each digit through the
// shared divider that retires eight quotient bits per cycle, emits a '-'
// for a negative value, and sends each character through the digit store's
// registered read port, a read state and then an emit state per character.
// Reset clears the queues and sets the radix to ten. When the receiver
// stalls, the two-entry output queue fills and the emitter waits; the input
// side keeps taking words until the job queue is full.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [5:0]                    cfg_radix_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    char_out_o,
  output logic                          last_char_o
);

  localparam int CTL_W = $bits(itoa_pkg::job_ctl_t);
  localparam int JOB_W = VALUE_WIDTH + CTL_W;
  localparam int OUT_W = $bits(itoa_pkg::char_word_t);

  itoa_pkg::job_ctl_t     front_ctl, back_ctl;
  logic [VALUE_WIDTH-1:0] front_mag, back_mag;
  logic [JOB_W-1:0]       job_rdata;
  logic                   job_empty, job_pop;
  itoa_pkg::char_word_t   out_word, head_word;
  logic                   out_full, out_push;
  logic [OUT_W-1:0]       head_bits;

  itoa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_radix_i (cfg_radix_i),
    .value_i     (value_i),
    .job_ctl_o   (front_ctl),
    .mag_o       (front_mag)
  );

  // Job queue between classification and conversion.
  itoa_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_ctl, front_mag}),
    .full_o  (full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  assign back_ctl = itoa_pkg::job_ctl_t'(job_rdata[JOB_W-1:VALUE_WIDTH]);
  assign back_mag = job_rdata[VALUE_WIDTH-1:0];

  itoa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_ctl_i   (back_ctl),
    .job_mag_i   (back_mag),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (out_word)
  );

  // Output queue decouples the emitter from the receiver.
  itoa_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (head_bits),
    .empty_o (empty)
  );

  assign head_word   = itoa_pkg::char_word_t'(head_bits);
  assign char_out_o  = head_word.ch;
  assign last_char_o = head_word.last;

endmodule

// File: design/itoa_fifo.sv
// ----------------------------------------------------------------------------
// itoa_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module itoa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Holds the radix register and classifies each incoming value.
// ----------------------------------------------------------------------------
module itoa_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [5:0]                    cfg_radix_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output itoa_pkg::job_ctl_t            job_ctl_o,
  output logic [VALUE_WIDTH-1:0]        mag_o
);

  logic [5:0]             radix_q;
  logic [5:0]             radix_eff;
  logic [VALUE_WIDTH-1:0] bits;
  logic                   neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itoa_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  // Out-of-range register values saturate to the nearest legal radix.
  always_comb begin
    if (radix_q < itoa_pkg::RADIX_MIN) begin
      radix_eff = itoa_pkg::RADIX_MIN;
    end else if (radix_q > itoa_pkg::RADIX_MAX) begin
      radix_eff = itoa_pkg::RADIX_MAX;
    end else begin
      radix_eff = radix_q;
    end
  end

  // Only decimal reads the value as signed; the magnitude of the most
  // negative value wraps to its true unsigned magnitude.
  assign bits  = value_i;
  assign neg   = (radix_eff == itoa_pkg::DECIMAL) && bits[VALUE_WIDTH-1];
  assign mag_o = neg ? (~bits + VALUE_WIDTH'(1)) : bits;

  assign job_ctl_o.neg   = neg;
  assign job_ctl_o.radix = radix_eff;

endmodule

// File: design/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// Divides the magnitude into digits, stores them, and emits characters
// most significant first.
// ----------------------------------------------------------------------------
module itoa_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_empty_i,
  input  itoa_pkg::job_ctl_t     job_ctl_i,
  input  logic [VALUE_WIDTH-1:0] job_mag_i,
  output logic                   job_pop_o,
  input  logic                   out_full_i,
  output logic                   out_push_o,
  output itoa_pkg::char_word_t   out_word_o
);

  localparam int W     = VALUE_WIDTH;
  localparam int AW    = $clog2(W);
  localparam int CW    = $clog2(W + 1);
  localparam int BW    = $clog2(W + 1);
  localparam int CHUNK = 8;

  itoa_pkg::back_state_e state_q, state_d;

  logic [W-1:0]  acc_q, acc_d, acc_v;
  logic [5:0]    rem_q, rem_d, rem_v;
  logic [6:0]    trial;
  logic [BW-1:0] bits_q, bits_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          neg_q, neg_d;
  logic [5:0]    radix_q, radix_d;
  logic          pass_done;

  logic [5:0]    store_q [W];
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic          st_re;
  logic [5:0]    rdata_q;

  // Restoring division by the radix, up to CHUNK quotient bits per cycle.
  always_comb begin
    rem_v = rem_q;
    acc_v = acc_q;
    trial = '0;
    for (int k = 0; k < CHUNK; k++) begin
      if (int'(bits_q) + k < W) begin
        trial = {rem_v, acc_v[W-1]};
        acc_v = {acc_v[W-2:0], 1'b0};
        if (trial >= {1'b0, radix_q}) begin
          trial    = trial - {1'b0, radix_q};
          acc_v[0] = 1'b1;
        end
        rem_v = trial[5:0];
      end
    end
    pass_done = (int'(bits_q) + CHUNK >= W);
  end

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    neg_d      = neg_q;
    radix_d    = radix_q;
    job_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_word_o = '0;
    st_we      = 1'b0;
    st_waddr   = cnt_q[AW-1:0];
    st_re      = 1'b0;
    unique case (state_q)
      itoa_pkg::BK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          acc_d     = job_mag_i;
          rem_d     = '0;
          bits_d    = '0;
          cnt_d     = '0;
          neg_d     = job_ctl_i.neg;
          radix_d   = job_ctl_i.radix;
          state_d   = itoa_pkg::BK_DIV;
        end
      end
      itoa_pkg::BK_DIV: begin
        acc_d = acc_v;
        rem_d = rem_v;
        if (pass_done) begin
          st_we  = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          bits_d = '0;
          rem_d  = '0;
          if (acc_v == '0) begin
            idx_d   = cnt_q[AW-1:0];
            state_d = neg_q ? itoa_pkg::BK_SIGN : itoa_pkg::BK_RD;
          end
        end else begin
          bits_d = bits_q + BW'(CHUNK);
        end
      end
      itoa_pkg::BK_SIGN: begin
        if (!out_full_i) begin
          out_push_o      = 1'b1;
          out_word_o.ch   = itoa_pkg::CH_MINUS;
          out_word_o.last = 1'b0;
          state_d         = itoa_pkg::BK_RD;
        end
      end
      itoa_pkg::BK_RD: begin
        st_re   = 1'b1;
        state_d = itoa_pkg::BK_EMIT;
      end
      itoa_pkg::BK_EMIT: begin
        if (!out_full_i) begin
          out_push_o      = 1'b1;
          out_word_o.last = (idx_q == '0);
          out_word_o.ch   = (rdata_q > 6'd9)
                          ? itoa_pkg::CH_LOWER_A + 8'(rdata_q - 6'd10)
                          : itoa_pkg::CH_ZERO + 8'(rdata_q);
          if (idx_q == '0) begin
            state_d = itoa_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = itoa_pkg::BK_RD;
          end
        end
      end
      default: begin
        state_d = itoa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::BK_IDLE;
      cnt_q   <= '0;
      bits_q  <= '0;
      idx_q   <= '0;
      neg_q   <= 1'b0;
      radix_q <= itoa_pkg::RADIX_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      idx_q   <= idx_d;
      neg_q   <= neg_d;
      radix_q <= radix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_q[st_waddr] <= rem_v;
    end
    if (st_re) begin
      rdata_q <= store_q[idx_q];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(W))
    else $error("digit count exceeds value width");

  a_radix_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_pkg::BK_DIV) |-> (radix_q >= itoa_pkg::RADIX_MIN &&
                                       radix_q <= itoa_pkg::RADIX_MAX))
    else $error("division running with an illegal radix");

  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> (state_q == itoa_pkg::BK_SIGN || state_q == itoa_pkg::BK_EMIT))
    else $error("character pushed outside an emit state");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_word_o.last) |=> (state_q == itoa_pkg::BK_IDLE))
    else $error("sequencer did not return to idle after the last character");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q == itoa_pkg::BK_DIV && cnt_q == '0))
    else $error("job taken without starting a fresh division");

endmodule
